FILE: rtl/igmp_report_membership_table_assert.svh
// Assertion macros used by the RTL top level.
`ifndef IGMP_REPORT_MEMBERSHIP_TABLE_ASSERT_SVH
`define IGMP_REPORT_MEMBERSHIP_TABLE_ASSERT_SVH
`ifndef SYNTHESIS
`define IRMT_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("irmt implication check failed");
`define IRMT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("irmt next-cycle check failed");
`else
`define IRMT_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define IRMT_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/irmt_pkg.sv
package irmt_pkg;

   localparam logic [2:0] STATUS_OK    = 3'd0;
   localparam logic [2:0] STATUS_CSUM  = 3'd1;
   localparam logic [2:0] STATUS_LEN   = 3'd2;
   localparam logic [2:0] STATUS_TYPE  = 3'd3;
   localparam logic [2:0] STATUS_TRUNC = 3'd4;

   localparam logic [7:0] MSG_V1_REPORT = 8'h12;
   localparam logic [7:0] MSG_V2_REPORT = 8'h16;
   localparam logic [7:0] MSG_V2_LEAVE  = 8'h17;
   localparam logic [7:0] MSG_V3_REPORT = 8'h22;

   localparam logic [7:0] REC_IS_INCLUDE = 8'd1;
   localparam logic [7:0] REC_IS_EXCLUDE = 8'd2;
   localparam logic [7:0] REC_TO_INCLUDE = 8'd3;
   localparam logic [7:0] REC_TO_EXCLUDE = 8'd4;

   localparam logic [16:0] CSUM_GOOD = 17'h0ffff;

   // wide enough for a record end position: pos + 8 + 4*65535 + 4*255
   localparam int SZW = 20;

   typedef enum logic [4:0] {
      S_IDLE, S_CHECK, S_HDR, S_HDR_DEC, S_REC_CHK, S_REC_RD, S_REC_SZ,
      S_G_INIT, S_G_RD, S_G_CMP, S_G_DONE, S_M_RD, S_M_CMP, S_M_DONE,
      S_L_RD, S_L_WR, S_L_END, S_Q_RD, S_RESP
   } state_type;

   typedef enum logic [4:0] {
      UOP_NONE, UOP_ACCEPT, UOP_CHECK, UOP_READ, UOP_HDR, UOP_RCHK, UOP_RSZ,
      UOP_GINIT, UOP_GRD, UOP_GCMP, UOP_GDONE, UOP_MRD, UOP_MCMP, UOP_MDONE,
      UOP_LRD, UOP_LWR, UOP_LEND, UOP_QRD, UOP_RESP
   } uop_type;

   typedef enum logic [1:0] {OP_NONE, OP_JOIN, OP_LEAVE, OP_QUERY} op_type;

   typedef struct packed {
      logic   chk_bad;
      logic   rd_done;
      logic   hdr_op;
      logic   hdr_v3;
      logic   v3;
      logic   rec_end;
      logic   rec_trunc;
      logic   size_bad;
      logic   rec_op;
      logic   g_hit;
      logic   g_last;
      logic   found;
      logic   free_found;
      op_type op;
      logic   m_end;
      logic   m_hit;
      logic   l_end;
      logic   rsp_free;
   } flags_type;

endpackage

FILE: rtl/igmp_report_membership_table.sv
// While the block is idle, message bytes without last_byte are taken one per cycle,
// with no result. A final byte is accepted, then the message is checked and its header
// fetched, each v3 record is read, the group table is searched, the member list is
// scanned with its list compaction, and the result register is loaded.
// A query searches the groups and reads a member; one item is in flight at a time.
// Synchronous active-high reset empties the group table and the message being collected.
`include "igmp_report_membership_table_assert.svh"
module igmp_report_membership_table #(
   parameter int MAX_MESSAGE_BYTES = 512,
   parameter int GROUP_SLOTS       = 16,
   parameter int MEMBERS_PER_GROUP = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_cmd,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   input  logic [31:0] req_sender_ip,
   input  logic [31:0] req_query_group,
   input  logic [2:0]  req_query_index,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_kind,
   output logic [2:0]  rsp_status,
   output logic [5:0]  rsp_joins_applied,
   output logic [5:0]  rsp_leaves_applied,
   output logic        rsp_capacity_dropped,
   output logic        rsp_group_found,
   output logic [3:0]  rsp_member_count,
   output logic [31:0] rsp_member_ip
);
   import irmt_pkg::*;

   uop_type   uop;
   flags_type flags;
   logic      status_quiet, answer_quiet;

   irmt_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_cmd(req_cmd),
      .req_last_byte(req_last_byte), .flags(flags), .uop(uop), .req_ready(req_ready)
   );

   irmt_dp #(
      .MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES),
      .GROUP_SLOTS(GROUP_SLOTS),
      .MEMBERS_PER_GROUP(MEMBERS_PER_GROUP)
   ) u_dp (
      .clock(clock), .reset(reset), .uop(uop), .flags(flags),
      .req_cmd(req_cmd), .req_data_byte(req_data_byte), .req_sender_ip(req_sender_ip),
      .req_query_group(req_query_group), .req_query_index(req_query_index),
      .rsp_ready(rsp_ready), .rsp_valid(rsp_valid), .rsp_kind(rsp_kind),
      .rsp_status(rsp_status), .rsp_joins_applied(rsp_joins_applied),
      .rsp_leaves_applied(rsp_leaves_applied),
      .rsp_capacity_dropped(rsp_capacity_dropped),
      .rsp_group_found(rsp_group_found), .rsp_member_count(rsp_member_count),
      .rsp_member_ip(rsp_member_ip)
   );

   assign status_quiet = !rsp_group_found && rsp_member_count == 4'd0 &&
                         rsp_member_ip == 32'd0;
   assign answer_quiet = rsp_status == STATUS_OK && rsp_joins_applied == 6'd0 &&
                         rsp_leaves_applied == 6'd0 && !rsp_capacity_dropped;

   `IRMT_ASSERT_IMPL(a_status_quiet, clock, reset, rsp_valid && !rsp_kind, status_quiet)
   `IRMT_ASSERT_IMPL(a_answer_quiet, clock, reset, rsp_valid && rsp_kind, answer_quiet)
   `IRMT_ASSERT_IMPL(a_status_range, clock, reset, rsp_valid, rsp_status <= STATUS_TRUNC)
   `IRMT_ASSERT_NEXT(a_query_busy, clock, reset, req_valid && req_ready && req_cmd, !req_ready)

endmodule

FILE: rtl/irmt_ram.sv
module irmt_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 512,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/irmt_ctrl.sv
module irmt_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_cmd,
   input  logic                req_last_byte,
   input  irmt_pkg::flags_type flags,
   output irmt_pkg::uop_type   uop,
   output logic                req_ready
);
   import irmt_pkg::*;

   state_type state_ff, state_in, after_op;

   assign after_op  = flags.v3 ? S_REC_CHK : S_RESP;
   assign req_ready = (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_cmd) state_in = S_G_INIT;
               else if (req_last_byte) state_in = S_CHECK;
            end
         end
         S_CHECK:   state_in = flags.chk_bad ? S_RESP : S_HDR;
         S_HDR:     if (flags.rd_done) state_in = S_HDR_DEC;
         S_HDR_DEC: begin
            if (flags.hdr_op) state_in = S_G_INIT;
            else if (flags.hdr_v3) state_in = S_REC_CHK;
            else state_in = S_RESP;
         end
         S_REC_CHK: begin
            if (flags.rec_end || flags.rec_trunc) state_in = S_RESP;
            else state_in = S_REC_RD;
         end
         S_REC_RD:  if (flags.rd_done) state_in = S_REC_SZ;
         S_REC_SZ: begin
            if (flags.size_bad) state_in = S_RESP;
            else if (flags.rec_op) state_in = S_G_INIT;
            else state_in = S_REC_CHK;
         end
         S_G_INIT:  state_in = S_G_RD;
         S_G_RD:    state_in = S_G_CMP;
         S_G_CMP:   state_in = (flags.g_hit || flags.g_last) ? S_G_DONE : S_G_RD;
         S_G_DONE: begin
            if (flags.op == OP_QUERY) state_in = S_Q_RD;
            else if (flags.found) state_in = S_M_RD;
            else if (flags.op == OP_JOIN && flags.free_found) state_in = S_M_DONE;
            else state_in = after_op;
         end
         S_M_RD:    state_in = flags.m_end ? S_M_DONE : S_M_CMP;
         S_M_CMP: begin
            if (!flags.m_hit) state_in = S_M_RD;
            else if (flags.op == OP_JOIN) state_in = after_op;
            else state_in = S_L_RD;
         end
         S_M_DONE:  state_in = after_op;
         S_L_RD:    state_in = flags.l_end ? S_L_END : S_L_WR;
         S_L_WR:    state_in = S_L_RD;
         S_L_END:   state_in = after_op;
         S_Q_RD:    state_in = S_RESP;
         S_RESP:    if (flags.rsp_free) state_in = S_IDLE;
         default:   state_in = S_IDLE;
      endcase
   end

   always_comb begin
      uop = UOP_NONE;
      case (state_ff)
         S_IDLE:    if (req_valid) uop = UOP_ACCEPT;
         S_CHECK:   uop = UOP_CHECK;
         S_HDR:     uop = UOP_READ;
         S_HDR_DEC: uop = UOP_HDR;
         S_REC_CHK: uop = UOP_RCHK;
         S_REC_RD:  uop = UOP_READ;
         S_REC_SZ:  uop = UOP_RSZ;
         S_G_INIT:  uop = UOP_GINIT;
         S_G_RD:    uop = UOP_GRD;
         S_G_CMP:   uop = UOP_GCMP;
         S_G_DONE:  uop = UOP_GDONE;
         S_M_RD:    if (!flags.m_end) uop = UOP_MRD;
         S_M_CMP:   uop = UOP_MCMP;
         S_M_DONE:  uop = UOP_MDONE;
         S_L_RD:    if (!flags.l_end) uop = UOP_LRD;
         S_L_WR:    uop = UOP_LWR;
         S_L_END:   uop = UOP_LEND;
         S_Q_RD:    uop = UOP_QRD;
         S_RESP:    if (flags.rsp_free) uop = UOP_RESP;
         default:   uop = UOP_NONE;
      endcase
   end

endmodule

FILE: rtl/irmt_dp.sv
module irmt_dp #(
   parameter int MAX_MESSAGE_BYTES = 512,
   parameter int GROUP_SLOTS       = 16,
   parameter int MEMBERS_PER_GROUP = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  irmt_pkg::uop_type   uop,
   output irmt_pkg::flags_type flags,
   input  logic                req_cmd,
   input  logic [7:0]          req_data_byte,
   input  logic [31:0]         req_sender_ip,
   input  logic [31:0]         req_query_group,
   input  logic [2:0]          req_query_index,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output logic                rsp_kind,
   output logic [2:0]          rsp_status,
   output logic [5:0]          rsp_joins_applied,
   output logic [5:0]          rsp_leaves_applied,
   output logic                rsp_capacity_dropped,
   output logic                rsp_group_found,
   output logic [3:0]          rsp_member_count,
   output logic [31:0]         rsp_member_ip
);
   import irmt_pkg::*;

   localparam int BW     = $clog2(MAX_MESSAGE_BYTES + 1);
   localparam int AW     = (MAX_MESSAGE_BYTES > 1) ? $clog2(MAX_MESSAGE_BYTES) : 1;
   localparam int GW     = (GROUP_SLOTS > 1) ? $clog2(GROUP_SLOTS) : 1;
   localparam int CW     = $clog2(MEMBERS_PER_GROUP + 1);
   localparam int MDEPTH = GROUP_SLOTS * MEMBERS_PER_GROUP;
   localparam int MAW    = (MDEPTH > 1) ? $clog2(MDEPTH) : 1;

   function automatic logic [MAW-1:0] maddr(input logic [GW-1:0] g, input logic [CW-1:0] i);
      maddr = MAW'(MAW'(g) * MAW'(MEMBERS_PER_GROUP) + MAW'(i));
   endfunction

   function automatic logic [5:0] sat_inc(input logic [5:0] v);
      sat_inc = (v == 6'h3f) ? v : v + 6'd1;
   endfunction

   logic [BW-1:0]  cnt_ff, cnt_in, len_ff, len_in, pos_ff, pos_in, rbase_ff, rbase_in;
   logic [16:0]    sum_ff, sum_in;
   logic           ovf_ff, ovf_in;
   logic [15:0]    nrec_ff, nrec_in, rcnt_ff, rcnt_in;
   logic [3:0]     rdi_ff, rdi_in;
   logic [63:0]    hdr_ff, hdr_in;
   logic [31:0]    ip_ff, ip_in, grp_ff, grp_in;
   logic [2:0]     qi_ff, qi_in, st_ff, st_in;
   op_type         op_ff, op_in;
   logic           v3_ff, v3_in;
   logic [5:0]     joins_ff, joins_in, leaves_ff, leaves_in;
   logic           drop_ff, drop_in;
   logic [GW-1:0]  gidx_ff, gidx_in, gsel_ff, gsel_in, free_ff, free_in;
   logic           found_ff, found_in, ffound_ff, ffound_in, qhit_ff, qhit_in;
   logic [CW-1:0]  midx_ff, midx_in;
   logic           gvalid_ff [GROUP_SLOTS];
   logic           gvalid_in [GROUP_SLOTS];
   logic [CW-1:0]  gcount_ff [GROUP_SLOTS];
   logic [CW-1:0]  gcount_in [GROUP_SLOTS];

   logic           rsp_valid_ff, rsp_valid_in, rsp_kind_ff, rsp_kind_in;
   logic [2:0]     rsp_status_ff, rsp_status_in;
   logic [5:0]     rsp_joins_ff, rsp_joins_in, rsp_leaves_ff, rsp_leaves_in;
   logic           rsp_drop_ff, rsp_drop_in, rsp_found_ff, rsp_found_in;
   logic [3:0]     rsp_count_ff, rsp_count_in;
   logic [31:0]    rsp_ip_ff, rsp_ip_in;

   logic           msg_we, msg_re;
   logic [AW-1:0]  msg_waddr, msg_raddr;
   logic [7:0]     msg_q;
   logic           g_we, g_re;
   logic [31:0]    g_q;
   logic           m_we, m_re;
   logic [MAW-1:0] m_waddr, m_raddr;
   logic [31:0]    m_wdata, m_q;

   logic [16:0]    sum_fold, sum_add, sum_raw;
   logic [BW-1:0]  rd_pos;
   logic [7:0]     msg_type, rec_type;
   logic [SZW-1:0] rec_size, rec_end_pos;
   logic [CW-1:0]  n;
   logic [CW:0]    midx_p1;
   logic           rsp_free;

   assign n        = gcount_ff[gsel_ff];
   assign midx_p1  = {1'b0, midx_ff} + (CW+1)'(1);
   assign sum_fold = 17'(sum_ff[15:0]) + 17'(sum_ff[16]);
   assign sum_add  = cnt_ff[0] ? 17'(req_data_byte) : 17'({req_data_byte, 8'h00});
   assign sum_raw  = sum_ff + sum_add;
   assign rd_pos   = rbase_ff + BW'(rdi_ff);
   assign msg_type = hdr_ff[63:56];
   assign rec_type = hdr_ff[63:56];
   assign rec_size = SZW'({hdr_ff[47:32], 2'b00}) + SZW'({hdr_ff[55:48], 2'b00}) + SZW'(8);
   assign rec_end_pos = SZW'(pos_ff) + rec_size;
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      flags.chk_bad    = ovf_ff || (sum_fold != CSUM_GOOD) ||
                         (cnt_ff != BW'(8) && cnt_ff < BW'(12));
      flags.rd_done    = (rdi_ff == 4'd8);
      flags.hdr_op     = (len_ff == BW'(8)) && (msg_type == MSG_V1_REPORT ||
                         msg_type == MSG_V2_REPORT || msg_type == MSG_V2_LEAVE);
      flags.hdr_v3     = (len_ff != BW'(8)) && (msg_type == MSG_V3_REPORT);
      flags.v3         = v3_ff;
      flags.rec_end    = (rcnt_ff == nrec_ff);
      flags.rec_trunc  = (SZW'(pos_ff) + SZW'(8)) > SZW'(len_ff);
      flags.size_bad   = rec_end_pos > SZW'(len_ff);
      flags.rec_op     = (rec_type == REC_IS_INCLUDE) || (rec_type == REC_IS_EXCLUDE) ||
                         (rec_type == REC_TO_INCLUDE) || (rec_type == REC_TO_EXCLUDE);
      flags.g_hit      = gvalid_ff[gidx_ff] && (g_q == grp_ff);
      flags.g_last     = (gidx_ff == GW'(GROUP_SLOTS - 1));
      flags.found      = found_ff;
      flags.free_found = ffound_ff;
      flags.op         = op_ff;
      flags.m_end      = (midx_ff == n);
      flags.m_hit      = (m_q == ip_ff);
      flags.l_end      = (midx_p1 >= {1'b0, n});
      flags.rsp_free   = rsp_free;
   end

   always_comb begin
      cnt_in = cnt_ff; len_in = len_ff; pos_in = pos_ff; rbase_in = rbase_ff;
      sum_in = sum_ff; ovf_in = ovf_ff; nrec_in = nrec_ff; rcnt_in = rcnt_ff;
      rdi_in = rdi_ff; hdr_in = hdr_ff; ip_in = ip_ff; grp_in = grp_ff;
      qi_in = qi_ff; st_in = st_ff; op_in = op_ff; v3_in = v3_ff;
      joins_in = joins_ff; leaves_in = leaves_ff; drop_in = drop_ff;
      gidx_in = gidx_ff; gsel_in = gsel_ff; free_in = free_ff;
      found_in = found_ff; ffound_in = ffound_ff; qhit_in = qhit_ff;
      midx_in = midx_ff; gvalid_in = gvalid_ff; gcount_in = gcount_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_kind_in = rsp_kind_ff; rsp_status_in = rsp_status_ff;
      rsp_joins_in = rsp_joins_ff; rsp_leaves_in = rsp_leaves_ff;
      rsp_drop_in = rsp_drop_ff; rsp_found_in = rsp_found_ff;
      rsp_count_in = rsp_count_ff; rsp_ip_in = rsp_ip_ff;
      msg_we = 1'b0; msg_re = 1'b0;
      msg_waddr = cnt_ff[AW-1:0]; msg_raddr = rd_pos[AW-1:0];
      g_we = 1'b0; g_re = 1'b0;
      m_we = 1'b0; m_re = 1'b0;
      m_waddr = maddr(gsel_ff, midx_ff); m_raddr = maddr(gsel_ff, midx_ff);
      m_wdata = ip_ff;
      case (uop)
         UOP_ACCEPT: begin
            if (req_cmd) begin
               grp_in = req_query_group;
               qi_in  = req_query_index;
               op_in  = OP_QUERY;
               v3_in  = 1'b0;
            end else begin
               ip_in = req_sender_ip;
               op_in = OP_NONE;
               if (cnt_ff < BW'(MAX_MESSAGE_BYTES)) begin
                  msg_we = 1'b1;
                  sum_in = 17'(sum_raw[15:0]) + 17'(sum_raw[16]);
                  cnt_in = cnt_ff + BW'(1);
               end else begin
                  ovf_in = 1'b1;
               end
            end
         end
         UOP_CHECK: begin
            len_in = cnt_ff;
            if (ovf_ff) st_in = STATUS_LEN;
            else if (sum_fold != CSUM_GOOD) st_in = STATUS_CSUM;
            else if (cnt_ff != BW'(8) && cnt_ff < BW'(12)) st_in = STATUS_LEN;
            else st_in = STATUS_OK;
            cnt_in = '0; sum_in = '0; ovf_in = 1'b0; v3_in = 1'b0;
            joins_in = '0; leaves_in = '0; drop_in = 1'b0;
            rbase_in = '0; rdi_in = '0;
         end
         UOP_READ: begin
            // one byte issued per cycle, shifted in on the cycle after
            if (rdi_ff < 4'd8) msg_re = 1'b1;
            if (rdi_ff != 4'd0) hdr_in = {hdr_ff[55:0], msg_q};
            rdi_in = rdi_ff + 4'd1;
         end
         UOP_HDR: begin
            if (flags.hdr_op) begin
               op_in  = (msg_type == MSG_V2_LEAVE) ? OP_LEAVE : OP_JOIN;
               grp_in = hdr_ff[31:0];
            end else if (flags.hdr_v3) begin
               v3_in   = 1'b1;
               nrec_in = hdr_ff[15:0];
               pos_in  = BW'(8);
               rcnt_in = '0;
            end else begin
               st_in = STATUS_TYPE;
            end
         end
         UOP_RCHK: begin
            if (!flags.rec_end && flags.rec_trunc) st_in = STATUS_TRUNC;
            rbase_in = pos_ff;
            rdi_in   = '0;
         end
         UOP_RSZ: begin
            if (flags.size_bad) begin
               st_in = STATUS_TRUNC;
            end else begin
               pos_in  = rec_end_pos[BW-1:0];
               rcnt_in = rcnt_ff + 16'd1;
               grp_in  = hdr_ff[31:0];
               if ((rec_type == REC_IS_INCLUDE || rec_type == REC_TO_INCLUDE) &&
                   hdr_ff[47:32] == 16'd0) op_in = OP_LEAVE;
               else op_in = OP_JOIN;
            end
         end
         UOP_GINIT: begin
            gidx_in = '0; found_in = 1'b0; ffound_in = 1'b0;
         end
         UOP_GRD: g_re = 1'b1;
         UOP_GCMP: begin
            if (flags.g_hit) begin
               found_in = 1'b1;
               gsel_in  = gidx_ff;
            end else if (!gvalid_ff[gidx_ff] && !ffound_ff) begin
               ffound_in = 1'b1;
               free_in   = gidx_ff;
            end
            if (!flags.g_last) gidx_in = gidx_ff + GW'(1);
         end
         UOP_GDONE: begin
            midx_in = '0;
            if (op_ff == OP_JOIN && !found_ff) begin
               if (ffound_ff) begin
                  g_we = 1'b1;
                  gvalid_in[free_ff] = 1'b1;
                  gcount_in[free_ff] = '0;
                  gsel_in = free_ff;
               end else begin
                  drop_in = 1'b1;
               end
            end
         end
         UOP_MRD: m_re = 1'b1;
         UOP_MCMP: begin
            if (flags.m_hit) begin
               if (op_ff == OP_JOIN) joins_in = sat_inc(joins_ff);
            end else begin
               midx_in = midx_ff + CW'(1);
            end
         end
         UOP_MDONE: begin
            if (op_ff == OP_JOIN) begin
               if (n == CW'(MEMBERS_PER_GROUP)) begin
                  drop_in = 1'b1;
               end else begin
                  m_we = 1'b1;
                  m_waddr = maddr(gsel_ff, n);
                  gcount_in[gsel_ff] = n + CW'(1);
                  joins_in = sat_inc(joins_ff);
               end
            end
         end
         UOP_LRD: begin
            m_re = 1'b1;
            m_raddr = maddr(gsel_ff, midx_p1[CW-1:0]);
         end
         UOP_LWR: begin
            // shift the next member down over the removed one
            m_we = 1'b1;
            m_wdata = m_q;
            midx_in = midx_p1[CW-1:0];
         end
         UOP_LEND: begin
            gcount_in[gsel_ff] = n - CW'(1);
            if (n == CW'(1)) gvalid_in[gsel_ff] = 1'b0;
            leaves_in = sat_inc(leaves_ff);
         end
         UOP_QRD: begin
            qhit_in = found_ff && (8'(qi_ff) < 8'(n));
            if (found_ff && (8'(qi_ff) < 8'(n))) begin
               m_re = 1'b1;
               m_raddr = maddr(gsel_ff, CW'(qi_ff));
            end
         end
         UOP_RESP: begin
            rsp_valid_in = 1'b1;
            if (op_ff == OP_QUERY) begin
               rsp_kind_in   = 1'b1;
               rsp_status_in = STATUS_OK;
               rsp_joins_in  = '0;
               rsp_leaves_in = '0;
               rsp_drop_in   = 1'b0;
               rsp_found_in  = found_ff;
               rsp_count_in  = found_ff ? 4'(n) : 4'd0;
               rsp_ip_in     = qhit_ff ? m_q : 32'd0;
            end else begin
               rsp_kind_in   = 1'b0;
               rsp_status_in = st_ff;
               rsp_joins_in  = joins_ff;
               rsp_leaves_in = leaves_ff;
               rsp_drop_in   = drop_ff;
               rsp_found_in  = 1'b0;
               rsp_count_in  = 4'd0;
               rsp_ip_in     = 32'd0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         sum_ff       <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < GROUP_SLOTS; i++) begin
            gvalid_ff[i] <= 1'b0;
            gcount_ff[i] <= '0;
         end
      end else begin
         cnt_ff       <= cnt_in;
         sum_ff       <= sum_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
         gvalid_ff    <= gvalid_in;
         gcount_ff    <= gcount_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff <= len_in; pos_ff <= pos_in; rbase_ff <= rbase_in;
      nrec_ff <= nrec_in; rcnt_ff <= rcnt_in; rdi_ff <= rdi_in; hdr_ff <= hdr_in;
      ip_ff <= ip_in; grp_ff <= grp_in; qi_ff <= qi_in; st_ff <= st_in;
      op_ff <= op_in; v3_ff <= v3_in; joins_ff <= joins_in; leaves_ff <= leaves_in;
      drop_ff <= drop_in; gidx_ff <= gidx_in; gsel_ff <= gsel_in; free_ff <= free_in;
      found_ff <= found_in; ffound_ff <= ffound_in; qhit_ff <= qhit_in;
      midx_ff <= midx_in;
      rsp_kind_ff <= rsp_kind_in; rsp_status_ff <= rsp_status_in;
      rsp_joins_ff <= rsp_joins_in; rsp_leaves_ff <= rsp_leaves_in;
      rsp_drop_ff <= rsp_drop_in; rsp_found_ff <= rsp_found_in;
      rsp_count_ff <= rsp_count_in; rsp_ip_ff <= rsp_ip_in;
   end

   irmt_ram #(.WIDTH(8), .DEPTH(MAX_MESSAGE_BYTES)) u_msg_ram (
      .clock(clock), .wr_en(msg_we), .wr_addr(msg_waddr), .wr_data(req_data_byte),
      .rd_en(msg_re), .rd_addr(msg_raddr), .rd_data(msg_q)
   );

   irmt_ram #(.WIDTH(32), .DEPTH(GROUP_SLOTS)) u_group_ram (
      .clock(clock), .wr_en(g_we), .wr_addr(free_ff), .wr_data(grp_ff),
      .rd_en(g_re), .rd_addr(gidx_ff), .rd_data(g_q)
   );

   irmt_ram #(.WIDTH(32), .DEPTH(MDEPTH)) u_member_ram (
      .clock(clock), .wr_en(m_we), .wr_addr(m_waddr), .wr_data(m_wdata),
      .rd_en(m_re), .rd_addr(m_raddr), .rd_data(m_q)
   );

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_kind             = rsp_kind_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_joins_applied    = rsp_joins_ff;
   assign rsp_leaves_applied   = rsp_leaves_ff;
   assign rsp_capacity_dropped = rsp_drop_ff;
   assign rsp_group_found      = rsp_found_ff;
   assign rsp_member_count     = rsp_count_ff;
   assign rsp_member_ip        = rsp_ip_ff;

endmodule
